// ===== src/mpc_pkg.sv =====
//------------------------------------------------------------------------------
// mpc_pkg: shared types, codes and helpers of the manhattan/45 polygon checker
// Widths, status and kind codes, queue item and result structs, and the
// grid rounding, clamping, edge check and verdict functions.
//------------------------------------------------------------------------------
package mpc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 4;

	localparam int SCALE_W    = 7;
	localparam int LC_W       = 9;
	localparam int MP_W       = 10;
	localparam int LAYER_W    = 8;
	localparam int LAYER_IN_W = 9;
	localparam int COUNT_W    = 10;
	localparam int STATUS_W   = 4;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// product of a coordinate and the scale, with room for every later sum
	localparam int WIDE_W = COORD_WIDTH + SCALE_W + 1;
	localparam int EDGE_W = COORD_WIDTH + 1;
	localparam int JSUM_W = COORD_WIDTH + 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_POINT  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_POLY    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RECT    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SBOX    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK    = 4'd0;
	localparam logic [STATUS_W-1:0] STAT_KIND  = 4'd1;
	localparam logic [STATUS_W-1:0] STAT_LAYER = 4'd2;
	localparam logic [STATUS_W-1:0] STAT_RECT  = 4'd3;
	localparam logic [STATUS_W-1:0] STAT_SBOX  = 4'd4;
	localparam logic [STATUS_W-1:0] STAT_MANY  = 4'd5;
	localparam logic [STATUS_W-1:0] STAT_FEW   = 4'd6;
	localparam logic [STATUS_W-1:0] STAT_ZERO  = 4'd7;
	localparam logic [STATUS_W-1:0] STAT_ANGLE = 4'd8;
	localparam logic [STATUS_W-1:0] STAT_GRID  = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SCALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_LIMIT = 2'd2;

	localparam logic [LC_W-1:0]    LAYER_COUNT_RST = 9'd16;
	localparam logic [SCALE_W-1:0] GRID_SCALE_RST  = 7'd4;
	localparam logic [MP_W-1:0]    POINT_LIMIT_RST = 10'd250;

	localparam logic [COUNT_W-1:0] RECT_POINTS = 10'd4;
	localparam logic [COUNT_W-1:0] SBOX_POINTS = 10'd2;
	localparam logic [COUNT_W-1:0] MIN_CORNERS = 10'd3;

	localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'((2 ** FRAC_BITS) / 2);
	localparam logic signed [WIDE_W-1:0] COORD_MAX_W =
		{{(WIDE_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] COORD_MIN_W = ~COORD_MAX_W;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [LC_W-1:0]    layer_count;
		logic [SCALE_W-1:0] grid_scale;
		logic [MP_W-1:0]    point_limit;
	} cfg_t;

	typedef struct packed {
		logic                cmd;
		logic [KIND_W-1:0]   kind;
		logic [LAYER_W-1:0]  layer;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] herr;
		coord_t              gx;
		coord_t              gy;
	} item_t;

	typedef struct packed {
		coord_t              gx;
		coord_t              gy;
		logic [LAYER_W-1:0]  layer;
		logic                last;
		logic [STATUS_W-1:0] status;
	} result_t;

	function automatic coord_t clamp_coord(input logic signed [WIDE_W-1:0] v);
		coord_t r;
		if (v > COORD_MAX_W)
			r = COORD_MAX_W[COORD_WIDTH-1:0];
		else if (v < COORD_MIN_W)
			r = COORD_MIN_W[COORD_WIDTH-1:0];
		else
			r = v[COORD_WIDTH-1:0];
		return r;
	endfunction

	// halves away from zero: negative values take one less bias
	function automatic coord_t round_grid(input logic signed [WIDE_W-1:0] p);
		logic signed [WIDE_W-1:0] biased;
		biased = p + ROUND_HALF;
		if (FRAC_BITS != 0 && p[WIDE_W-1])
			biased = biased - WIDE_W'(1);
		return clamp_coord(biased >>> FRAC_BITS);
	endfunction

	function automatic logic [STATUS_W-1:0] check_edge(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by);
		logic signed [EDGE_W-1:0] dx;
		logic signed [EDGE_W-1:0] dy;
		logic [STATUS_W-1:0] r;
		dx = EDGE_W'(bx) - EDGE_W'(ax);
		dy = EDGE_W'(by) - EDGE_W'(ay);
		r = STAT_OK;
		if (dx == '0 && dy == '0)
			r = STAT_ZERO;
		else if (dx != '0 && dy != '0) begin
			if (dx != dy && dx != -dy)
				r = STAT_ANGLE;
			else if (bx[0] ^ by[0])
				r = STAT_GRID;
		end
		return r;
	endfunction

	function automatic logic [STATUS_W-1:0] verdict(input logic [KIND_W-1:0] kind,
			input logic [COUNT_W-1:0] seen, input logic [STATUS_W-1:0] err);
		logic [STATUS_W-1:0] r;
		r = err;
		if (kind != KIND_SBOX && seen < MIN_CORNERS && (err == STAT_OK || err >= STAT_ZERO))
			r = STAT_FEW;
		return r;
	endfunction

endpackage

// ===== src/mpc_front.sv =====
//------------------------------------------------------------------------------
// mpc_front: input stage of the polygon checker
// Takes items, checks headers against the configuration, scales and rounds
// points onto the grid over two pipeline stages, and pushes into the queue.
//------------------------------------------------------------------------------
module mpc_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   command,
	input  logic [mpc_pkg::KIND_W-1:0]             element_kind,
	input  logic signed [mpc_pkg::LAYER_IN_W-1:0]  layer_index,
	input  logic [mpc_pkg::COUNT_W-1:0]            point_count,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] coord_x,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] coord_y,
	input  mpc_pkg::cfg_t                          cfg,
	input  logic                                   q_full,
	output logic                                   q_push,
	output mpc_pkg::item_t                         q_item
);

	logic                                 s1_v_q;
	logic                                 s2_v_q;
	logic                                 adv1;
	logic                                 adv2;
	logic [mpc_pkg::STATUS_W-1:0]         herr;
	logic signed [mpc_pkg::SCALE_W:0]     scale_s;
	logic signed [mpc_pkg::WIDE_W-1:0]    prod_x;
	logic signed [mpc_pkg::WIDE_W-1:0]    prod_y;

	logic                                 cmd_s1;
	logic [mpc_pkg::KIND_W-1:0]           kind_s1;
	logic [mpc_pkg::LAYER_W-1:0]          layer_s1;
	logic [mpc_pkg::COUNT_W-1:0]          count_s1;
	logic [mpc_pkg::STATUS_W-1:0]         herr_s1;
	logic signed [mpc_pkg::WIDE_W-1:0]    prod_x_s1;
	logic signed [mpc_pkg::WIDE_W-1:0]    prod_y_s1;
	mpc_pkg::item_t                       item_s2;

	assign adv2   = !s2_v_q || !q_full;
	assign adv1   = !s1_v_q || adv2;
	assign full   = !adv1;
	assign q_push = s2_v_q;
	assign q_item = item_s2;

	// header checks, first failing one wins
	always_comb begin
		priority if (element_kind == mpc_pkg::KIND_UNKNOWN)
			herr = mpc_pkg::STAT_KIND;
		else if (layer_index[mpc_pkg::LAYER_IN_W-1]
				|| ({1'b0, layer_index[mpc_pkg::LAYER_W-1:0]} >= cfg.layer_count))
			herr = mpc_pkg::STAT_LAYER;
		else if (element_kind == mpc_pkg::KIND_RECT && point_count != mpc_pkg::RECT_POINTS)
			herr = mpc_pkg::STAT_RECT;
		else if (element_kind == mpc_pkg::KIND_SBOX && point_count != mpc_pkg::SBOX_POINTS)
			herr = mpc_pkg::STAT_SBOX;
		else if (point_count > cfg.point_limit)
			herr = mpc_pkg::STAT_MANY;
		else
			herr = mpc_pkg::STAT_OK;
	end

	assign scale_s = {1'b0, cfg.grid_scale};
	assign prod_x  = mpc_pkg::WIDE_W'(coord_x) * mpc_pkg::WIDE_W'(scale_s);
	assign prod_y  = mpc_pkg::WIDE_W'(coord_y) * mpc_pkg::WIDE_W'(scale_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (adv1)
				s1_v_q <= push;
			if (adv2)
				s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1    <= command;
			kind_s1   <= element_kind;
			layer_s1  <= layer_index[mpc_pkg::LAYER_W-1:0];
			count_s1  <= point_count;
			herr_s1   <= herr;
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
		end
		if (adv2) begin
			item_s2.cmd   <= cmd_s1;
			item_s2.kind  <= kind_s1;
			item_s2.layer <= layer_s1;
			item_s2.count <= count_s1;
			item_s2.herr  <= herr_s1;
			item_s2.gx    <= mpc_pkg::round_grid(prod_x_s1);
			item_s2.gy    <= mpc_pkg::round_grid(prod_y_s1);
		end
	end

endmodule

// ===== src/mpc_queue.sv =====
//------------------------------------------------------------------------------
// mpc_queue: short item queue between the front and the back
// Register-based fifo of classified items; the head is shown while valid.
//------------------------------------------------------------------------------
module mpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mpc_pkg::item_t item_in,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output mpc_pkg::item_t item_out
);

	localparam int AW = $clog2(mpc_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(mpc_pkg::QUEUE_DEPTH + 1);

	mpc_pkg::item_t mem_q [mpc_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full     = cnt_q == CW'(mpc_pkg::QUEUE_DEPTH);
	assign valid    = cnt_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + AW'(1);
			if (do_pop)
				rd_q <= rd_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= item_in;
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(mpc_pkg::QUEUE_DEPTH))
		else $error("item queue count beyond depth");
`endif

endmodule

// ===== src/mpc_back.sv =====
//------------------------------------------------------------------------------
// mpc_back: element sequencer and result queue of the polygon checker
// Tracks the open element, checks edges, expands slanted boxes into four
// corners and writes results into a small output fifo.
//------------------------------------------------------------------------------
module mpc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mpc_pkg::item_t   q_item,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output mpc_pkg::result_t head
);

	typedef enum logic [3:0] {
		SQ_RUN  = 4'b0001,
		SQ_SUM  = 4'b0010,
		SQ_CORN = 4'b0100,
		SQ_EMIT = 4'b1000
	} seq_state_t;

	localparam int OQ_AW = $clog2(mpc_pkg::OUT_DEPTH);
	localparam int OQ_CW = $clog2(mpc_pkg::OUT_DEPTH + 1);

	seq_state_t                    state_q, state_d;
	logic [mpc_pkg::COUNT_W-1:0]   left_q, left_d;
	logic [mpc_pkg::COUNT_W-1:0]   seen_q, seen_d;
	logic [mpc_pkg::KIND_W-1:0]    kind_q, kind_d;
	logic [mpc_pkg::LAYER_W-1:0]   layer_q, layer_d;
	logic [mpc_pkg::STATUS_W-1:0]  err_q, err_d;
	logic                          sbox_q, sbox_d;
	logic [1:0]                    k_q, k_d;

	mpc_pkg::coord_t               first_x_q, first_y_q, first_x_d, first_y_d;
	mpc_pkg::coord_t               prev_x_q, prev_y_q, prev_x_d, prev_y_d;
	mpc_pkg::coord_t               c1x_q, c1y_q, c3x_q, c3y_q;
	mpc_pkg::coord_t               c1x_d, c1y_d, c3x_d, c3y_d;
	logic signed [mpc_pkg::JSUM_W-1:0] j_q, j_d;
	logic signed [mpc_pkg::JSUM_W-1:0] jsum;
	logic signed [mpc_pkg::JSUM_W-1:0] jsum_r;

	mpc_pkg::coord_t               gx, gy;
	mpc_pkg::coord_t               fsx, fsy;
	logic [mpc_pkg::STATUS_W-1:0]  e1, e2, err_a, err_b;
	logic [mpc_pkg::COUNT_W-1:0]   seen_inc;
	mpc_pkg::coord_t               cur_x, cur_y, nxt_x, nxt_y;
	logic [mpc_pkg::STATUS_W-1:0]  ek, err_e;

	logic                          o_push;
	mpc_pkg::result_t              o_data;
	logic                          o_space;
	logic                          o_pop;
	mpc_pkg::result_t              oq_mem [mpc_pkg::OUT_DEPTH];
	logic [OQ_AW-1:0]              oq_wr_q;
	logic [OQ_AW-1:0]              oq_rd_q;
	logic [OQ_CW-1:0]              oq_cnt_q;

	// edge checks of an ordinary point
	assign gx       = q_item.gx;
	assign gy       = q_item.gy;
	assign fsx      = (seen_q == '0) ? gx : first_x_q;
	assign fsy      = (seen_q == '0) ? gy : first_y_q;
	assign e1       = mpc_pkg::check_edge(prev_x_q, prev_y_q, gx, gy);
	assign e2       = mpc_pkg::check_edge(gx, gy, fsx, fsy);
	assign err_a    = (err_q != mpc_pkg::STAT_OK || seen_q == '0) ? err_q : e1;
	assign err_b    = (err_a != mpc_pkg::STAT_OK || left_q != mpc_pkg::COUNT_W'(1)) ? err_a : e2;
	assign seen_inc = seen_q + mpc_pkg::COUNT_W'(1);

	// slanted box: diagonal offset, truncated toward zero
	assign jsum   = (mpc_pkg::JSUM_W'(prev_x_q) - mpc_pkg::JSUM_W'(first_x_q))
			+ (mpc_pkg::JSUM_W'(prev_y_q) - mpc_pkg::JSUM_W'(first_y_q));
	assign jsum_r = jsum + {{(mpc_pkg::JSUM_W - 1){1'b0}}, jsum[mpc_pkg::JSUM_W-1]};

	// corner k and its successor around the box
	always_comb begin
		unique case (k_q)
			2'd0: begin
				cur_x = first_x_q; cur_y = first_y_q; nxt_x = c1x_q;     nxt_y = c1y_q;
			end
			2'd1: begin
				cur_x = c1x_q;     cur_y = c1y_q;     nxt_x = prev_x_q;  nxt_y = prev_y_q;
			end
			2'd2: begin
				cur_x = prev_x_q;  cur_y = prev_y_q;  nxt_x = c3x_q;     nxt_y = c3y_q;
			end
			default: begin
				cur_x = c3x_q;     cur_y = c3y_q;     nxt_x = first_x_q; nxt_y = first_y_q;
			end
		endcase
	end

	assign ek    = mpc_pkg::check_edge(cur_x, cur_y, nxt_x, nxt_y);
	assign err_e = (err_q != mpc_pkg::STAT_OK) ? err_q : ek;

	always_comb begin
		state_d   = state_q;
		left_d    = left_q;
		seen_d    = seen_q;
		kind_d    = kind_q;
		layer_d   = layer_q;
		err_d     = err_q;
		sbox_d    = sbox_q;
		k_d       = k_q;
		first_x_d = first_x_q;
		first_y_d = first_y_q;
		prev_x_d  = prev_x_q;
		prev_y_d  = prev_y_q;
		c1x_d     = c1x_q;
		c1y_d     = c1y_q;
		c3x_d     = c3x_q;
		c3y_d     = c3y_q;
		j_d       = j_q;
		q_pop     = 1'b0;
		o_push    = 1'b0;
		o_data    = '0;
		unique case (state_q)
			SQ_RUN: begin
				if (q_valid && o_space) begin
					q_pop = 1'b1;
					if (q_item.cmd == mpc_pkg::CMD_HEADER) begin
						kind_d  = q_item.kind;
						layer_d = q_item.layer;
						left_d  = q_item.count;
						seen_d  = '0;
						err_d   = q_item.herr;
						sbox_d  = q_item.kind == mpc_pkg::KIND_SBOX
								&& q_item.count == mpc_pkg::SBOX_POINTS;
						if (q_item.count == '0) begin
							o_push        = 1'b1;
							o_data.layer  = q_item.layer;
							o_data.last   = 1'b1;
							o_data.status = mpc_pkg::verdict(q_item.kind, '0, q_item.herr);
						end
					end else if (left_q != '0) begin
						prev_x_d = gx;
						prev_y_d = gy;
						if (sbox_q) begin
							if (seen_q == '0) begin
								first_x_d = gx;
								first_y_d = gy;
								seen_d    = mpc_pkg::COUNT_W'(1);
								left_d    = mpc_pkg::COUNT_W'(1);
							end else begin
								seen_d  = mpc_pkg::SBOX_POINTS;
								left_d  = '0;
								state_d = SQ_SUM;
							end
						end else begin
							if (seen_q == '0) begin
								first_x_d = gx;
								first_y_d = gy;
							end
							seen_d      = seen_inc;
							left_d      = left_q - mpc_pkg::COUNT_W'(1);
							err_d       = err_b;
							o_push      = 1'b1;
							o_data.gx   = gx;
							o_data.gy   = gy;
							o_data.layer = layer_q;
							o_data.last = left_q == mpc_pkg::COUNT_W'(1);
							if (left_q == mpc_pkg::COUNT_W'(1))
								o_data.status = mpc_pkg::verdict(kind_q, seen_inc, err_b);
						end
					end
				end
			end
			SQ_SUM: begin
				j_d     = jsum_r >>> 1;
				state_d = SQ_CORN;
			end
			SQ_CORN: begin
				c1x_d   = mpc_pkg::clamp_coord(mpc_pkg::WIDE_W'(first_x_q) + mpc_pkg::WIDE_W'(j_q));
				c1y_d   = mpc_pkg::clamp_coord(mpc_pkg::WIDE_W'(first_y_q) + mpc_pkg::WIDE_W'(j_q));
				c3x_d   = mpc_pkg::clamp_coord(mpc_pkg::WIDE_W'(prev_x_q) - mpc_pkg::WIDE_W'(j_q));
				c3y_d   = mpc_pkg::clamp_coord(mpc_pkg::WIDE_W'(prev_y_q) - mpc_pkg::WIDE_W'(j_q));
				k_d     = 2'd0;
				state_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				if (o_space) begin
					err_d        = err_e;
					o_push       = 1'b1;
					o_data.gx    = cur_x;
					o_data.gy    = cur_y;
					o_data.layer = layer_q;
					o_data.last  = k_q == 2'd3;
					k_d          = k_q + 2'd1;
					if (k_q == 2'd3) begin
						o_data.status = mpc_pkg::verdict(kind_q, seen_q, err_e);
						state_d       = SQ_RUN;
					end
				end
			end
			default: state_d = SQ_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_RUN;
			left_q  <= '0;
			seen_q  <= '0;
			kind_q  <= mpc_pkg::KIND_POLY;
			layer_q <= '0;
			err_q   <= mpc_pkg::STAT_OK;
			sbox_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			kind_q  <= kind_d;
			layer_q <= layer_d;
			err_q   <= err_d;
			sbox_q  <= sbox_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		first_x_q <= first_x_d;
		first_y_q <= first_y_d;
		prev_x_q  <= prev_x_d;
		prev_y_q  <= prev_y_d;
		c1x_q     <= c1x_d;
		c1y_q     <= c1y_d;
		c3x_q     <= c3x_d;
		c3y_q     <= c3y_d;
		j_q       <= j_d;
	end

	// result fifo
	assign o_space = oq_cnt_q < OQ_CW'(mpc_pkg::OUT_DEPTH);
	assign empty   = oq_cnt_q == '0;
	assign o_pop   = pop && !empty;
	assign head    = oq_mem[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (o_push)
				oq_wr_q <= oq_wr_q + OQ_AW'(1);
			if (o_pop)
				oq_rd_q <= oq_rd_q + OQ_AW'(1);
			if (o_push && !o_pop)
				oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
			else if (o_pop && !o_push)
				oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (o_push)
			oq_mem[oq_wr_q] <= o_data;
	end

`ifndef ASSERT_OFF
	a_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == SQ_RUN)
		else $error("item taken while a box is being expanded");
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OQ_CW'(mpc_pkg::OUT_DEPTH))
		else $error("result fifo count beyond depth");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		err_q <= mpc_pkg::STAT_GRID)
		else $error("recorded error outside the status codes");
`endif

endmodule

// ===== src/manhattan45_polygon_checker.sv =====
//------------------------------------------------------------------------------
// manhattan45_polygon_checker: checker for manhattan and 45 degree polygons
// Top level: configuration registers, input front, item queue and sequencer.
//------------------------------------------------------------------------------
// Usage:
//   input side is a queue: an item is taken when push is high and full low.
//   A header item opens an element, point items follow; points are scaled by
//   grid_scale and rounded to the grid, slanted boxes become four corners.
//   Result side is a queue: while empty is low the oldest result is on
//   grid_x, grid_y, layer, last, status; pop takes it. The last result of
//   an element carries the first error or 6 (too few corners), others carry 0.
//   Configuration writes go through cfg_valid/cfg_ready (always ready),
//   register index on cfg_index, value on cfg_data; write only when idle.
// Timing:
//   an item passes the two front stages and the item queue, and its result
//   goes into the result fifo. One item per cycle is sustained when nothing
//   stalls; the second point of a slanted box holds the sequencer (fetch,
//   offset sum, corners, then one corner per cycle while the fifo has room).
//   If the receiver stops popping, the 4-entry result fifo, the 4-entry item
//   queue and the 2 front stages fill up, then full goes high.
// Reset: asynchronous, clears queues and element state; registers return to
//   layer_count 16, grid_scale 4, point_limit 250.
//------------------------------------------------------------------------------
module manhattan45_polygon_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   command,
	input  logic [mpc_pkg::KIND_W-1:0]             element_kind,
	input  logic signed [mpc_pkg::LAYER_IN_W-1:0]  layer_index,
	input  logic [mpc_pkg::COUNT_W-1:0]            point_count,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] coord_x,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] coord_y,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [mpc_pkg::COORD_WIDTH-1:0] grid_x,
	output logic signed [mpc_pkg::COORD_WIDTH-1:0] grid_y,
	output logic [mpc_pkg::LAYER_W-1:0]            layer,
	output logic                                   last,
	output logic [mpc_pkg::STATUS_W-1:0]           status,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mpc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mpc_pkg::CFG_DATA_W-1:0]         cfg_data
);

	mpc_pkg::cfg_t    cfg_q;
	logic             q_full;
	logic             q_push;
	mpc_pkg::item_t   q_in;
	logic             q_valid;
	logic             q_pop;
	mpc_pkg::item_t   q_head;
	mpc_pkg::result_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layer_count <= mpc_pkg::LAYER_COUNT_RST;
			cfg_q.grid_scale  <= mpc_pkg::GRID_SCALE_RST;
			cfg_q.point_limit <= mpc_pkg::POINT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mpc_pkg::REG_LAYER_COUNT: cfg_q.layer_count <= cfg_data[mpc_pkg::LC_W-1:0];
				mpc_pkg::REG_GRID_SCALE:  cfg_q.grid_scale  <= cfg_data[mpc_pkg::SCALE_W-1:0];
				mpc_pkg::REG_POINT_LIMIT: cfg_q.point_limit <= cfg_data[mpc_pkg::MP_W-1:0];
				default: ;
			endcase
		end
	end

	mpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.element_kind (element_kind),
		.layer_index  (layer_index),
		.point_count  (point_count),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_in)
	);

	mpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.item_out (q_head)
	);

	mpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	assign grid_x = head.gx;
	assign grid_y = head.gy;
	assign layer  = head.layer;
	assign last   = head.last;
	assign status = head.status;

endmodule

// ===== tb/corner_checker.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// corner_checker: prediction and comparison of polygon checker results
// Watches the register write channel, the item queue and the result queue,
// keeps its own copy of the element state and registers, works out the
// corners and verdict each accepted item causes, and compares every popped
// result field by field with the oldest pending corner.
//------------------------------------------------------------------------------
module corner_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic                                   full,
	input  logic                                   command,
	input  logic [mpc_pkg::KIND_W-1:0]             element_kind,
	input  logic signed [mpc_pkg::LAYER_IN_W-1:0]  layer_index,
	input  logic [mpc_pkg::COUNT_W-1:0]            point_count,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] coord_x,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] coord_y,
	input  logic                                   empty,
	input  logic                                   pop,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] grid_x,
	input  logic signed [mpc_pkg::COORD_WIDTH-1:0] grid_y,
	input  logic [mpc_pkg::LAYER_W-1:0]            layer,
	input  logic                                   last,
	input  logic [mpc_pkg::STATUS_W-1:0]           status,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [mpc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mpc_pkg::CFG_DATA_W-1:0]         cfg_data,
	output int                                     mismatches,
	output int                                     corners_checked,
	output int                                     corners_due_count
);
	import mpc_pkg::*;

	result_t corners_due[$];

	logic [LC_W-1:0]     cfg_layers;
	logic [SCALE_W-1:0]  cfg_scale;
	logic [MP_W-1:0]     cfg_max;

	longint              first_x, first_y, prev_x, prev_y;
	logic [COUNT_W-1:0]  left_cnt, seen_cnt;
	logic [KIND_W-1:0]   open_kind;
	logic [LAYER_W-1:0]  open_layer;
	logic [STATUS_W-1:0] open_err;

	initial begin
		mismatches = 0;
		corners_checked = 0;
		corners_due_count = 0;
	end

	function automatic longint sat_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// scale, then round halves away from zero
	function automatic longint grid_of(input logic signed [COORD_WIDTH-1:0] raw);
		longint prod;
		longint mag_v;
		longint rounded;
		prod = longint'(raw) * longint'(cfg_scale);
		mag_v = (prod < 0) ? -prod : prod;
		rounded = (mag_v + longint'(2 ** FRAC_BITS) / 2) >>> FRAC_BITS;
		return sat_coord((prod < 0) ? -rounded : rounded);
	endfunction

	function automatic logic [STATUS_W-1:0] edge_code(input longint ax, input longint ay,
			input longint bx, input longint by);
		longint dx;
		longint dy;
		dx = bx - ax;
		dy = by - ay;
		if (dx == 0 && dy == 0)
			return STAT_ZERO;
		if (dx != 0 && dy != 0) begin
			if (((dx < 0) ? -dx : dx) != ((dy < 0) ? -dy : dy))
				return STAT_ANGLE;
			if (((bx ^ by) & 1) != 0)
				return STAT_GRID;
		end
		return STAT_OK;
	endfunction

	// only the first error of an element is kept
	task automatic note_edge(input longint ax, input longint ay, input longint bx,
			input longint by);
		if (open_err == STAT_OK)
			open_err = edge_code(ax, ay, bx, by);
	endtask

	function automatic logic [STATUS_W-1:0] close_status();
		if (open_kind != KIND_SBOX && seen_cnt < MIN_CORNERS &&
				(open_err == STAT_OK || open_err >= STAT_ZERO))
			return STAT_FEW;
		return open_err;
	endfunction

	task automatic queue_corner(input longint x, input longint y, input logic fin,
			input logic [STATUS_W-1:0] st);
		result_t r;
		r.gx = x[COORD_WIDTH-1:0];
		r.gy = y[COORD_WIDTH-1:0];
		r.layer = open_layer;
		r.last = fin;
		r.status = st;
		corners_due.push_back(r);
	endtask

	task automatic predict_corners(input logic cmd_in, input logic [KIND_W-1:0] kind_in,
			input logic signed [LAYER_IN_W-1:0] layer_in, input logic [COUNT_W-1:0] count_in,
			input logic signed [COORD_WIDTH-1:0] x_in, input logic signed [COORD_WIDTH-1:0] y_in);
		longint gx, gy, jump;
		longint cx[4];
		longint cy[4];
		int k;
		if (cmd_in == CMD_HEADER) begin
			// a header also drops any element still open
			open_kind = kind_in;
			open_layer = layer_in[LAYER_W-1:0];
			left_cnt = count_in;
			seen_cnt = '0;
			open_err = STAT_OK;
			if (kind_in == KIND_UNKNOWN)
				open_err = STAT_KIND;
			else if (layer_in < 0 || int'(layer_in) >= int'(cfg_layers))
				open_err = STAT_LAYER;
			else if (kind_in == KIND_RECT && count_in != RECT_POINTS)
				open_err = STAT_RECT;
			else if (kind_in == KIND_SBOX && count_in != SBOX_POINTS)
				open_err = STAT_SBOX;
			else if (count_in > cfg_max)
				open_err = STAT_MANY;
			if (count_in == '0)
				queue_corner(0, 0, 1'b1, close_status());
			return;
		end
		if (left_cnt == '0)
			return;
		gx = grid_of(x_in);
		gy = grid_of(y_in);
		if (open_kind == KIND_SBOX && int'(seen_cnt) + int'(left_cnt) == 2) begin
			if (seen_cnt == '0) begin
				first_x = gx;
				first_y = gy;
				prev_x = gx;
				prev_y = gy;
				seen_cnt = COUNT_W'(1);
				left_cnt = COUNT_W'(1);
				return;
			end
			cx[0] = first_x;
			cy[0] = first_y;
			cx[2] = gx;
			cy[2] = gy;
			jump = ((cx[2] - cx[0]) + (cy[2] - cy[0])) / 2;
			cx[1] = sat_coord(cx[0] + jump);
			cy[1] = sat_coord(cy[0] + jump);
			cx[3] = sat_coord(cx[2] - jump);
			cy[3] = sat_coord(cy[2] - jump);
			for (k = 0; k < 4; k++)
				note_edge(cx[k], cy[k], cx[(k + 1) % 4], cy[(k + 1) % 4]);
			prev_x = gx;
			prev_y = gy;
			seen_cnt = COUNT_W'(2);
			left_cnt = '0;
			for (k = 0; k < 3; k++)
				queue_corner(cx[k], cy[k], 1'b0, STAT_OK);
			queue_corner(cx[3], cy[3], 1'b1, close_status());
			return;
		end
		if (seen_cnt == '0) begin
			first_x = gx;
			first_y = gy;
		end else begin
			note_edge(prev_x, prev_y, gx, gy);
		end
		prev_x = gx;
		prev_y = gy;
		seen_cnt = seen_cnt + 1'b1;
		left_cnt = left_cnt - 1'b1;
		if (left_cnt == '0) begin
			note_edge(gx, gy, first_x, first_y);
			queue_corner(gx, gy, 1'b1, close_status());
		end else begin
			queue_corner(gx, gy, 1'b0, STAT_OK);
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: result %0d: %s", $time, corners_checked, msg);
	endtask

	task automatic check_corner();
		result_t want;
		if (corners_due.size() == 0) begin
			report_mismatch($sformatf("corner (%0d,%0d) with nothing pending", grid_x, grid_y));
			return;
		end
		want = corners_due.pop_front();
		corners_checked++;
		if (grid_x !== want.gx)
			report_mismatch($sformatf("grid_x %0d, expected %0d", grid_x, want.gx));
		if (grid_y !== want.gy)
			report_mismatch($sformatf("grid_y %0d, expected %0d", grid_y, want.gy));
		if (layer !== want.layer)
			report_mismatch($sformatf("layer %0d, expected %0d", layer, want.layer));
		if (last !== want.last)
			report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
		if (status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_layers = LAYER_COUNT_RST;
			cfg_scale = GRID_SCALE_RST;
			cfg_max = POINT_LIMIT_RST;
			first_x = 0;
			first_y = 0;
			prev_x = 0;
			prev_y = 0;
			left_cnt = '0;
			seen_cnt = '0;
			open_kind = KIND_POLY;
			open_layer = '0;
			open_err = STAT_OK;
			corners_due.delete();
			corners_due_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LAYER_COUNT: cfg_layers = cfg_data[LC_W-1:0];
					REG_GRID_SCALE:  cfg_scale = cfg_data[SCALE_W-1:0];
					REG_POINT_LIMIT: cfg_max = cfg_data[MP_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty)
				check_corner();
			if (push && !full)
				predict_corners(command, element_kind, layer_index, point_count,
					coord_x, coord_y);
			corners_due_count <= corners_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top: testbench of the manhattan/45 polygon checker
// Drives directed elements, then random polygons, rectangles, slanted boxes
// and malformed streams under several register settings, with random gaps
// on both queues; results are predicted and compared by corner_checker.
//------------------------------------------------------------------------------
module tb_top;
	import mpc_pkg::*;

	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 160;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          command = 1'b0;
	logic [KIND_W-1:0]             element_kind = '0;
	logic signed [LAYER_IN_W-1:0]  layer_index = '0;
	logic [COUNT_W-1:0]            point_count = '0;
	logic signed [COORD_WIDTH-1:0] coord_x = '0;
	logic signed [COORD_WIDTH-1:0] coord_y = '0;
	logic                          pop = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;

	logic                          full, empty, last, cfg_ready;
	logic signed [COORD_WIDTH-1:0] grid_x, grid_y;
	logic [LAYER_W-1:0]            layer;
	logic [STATUS_W-1:0]           status;

	int mismatches, corners_checked, corners_due_count;
	int push_mode = 0;
	int pop_mode = 0;
	bit hold_off_pop = 1'b0;
	int items_sent = 0;
	int strays_sent = 0;
	int reg_writes = 0;
	int settings_used = 0;
	int cur_layers = 16;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	manhattan45_polygon_checker uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .element_kind(element_kind), .layer_index(layer_index),
		.point_count(point_count), .coord_x(coord_x), .coord_y(coord_y),
		.empty(empty), .pop(pop),
		.grid_x(grid_x), .grid_y(grid_y), .layer(layer), .last(last), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	corner_checker corner_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .element_kind(element_kind), .layer_index(layer_index),
		.point_count(point_count), .coord_x(coord_x), .coord_y(coord_y),
		.empty(empty), .pop(pop),
		.grid_x(grid_x), .grid_y(grid_y), .layer(layer), .last(last), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches), .corners_checked(corners_checked),
		.corners_due_count(corners_due_count)
	);

	// mode 0: no gaps, 1: uniform gaps, 2: mostly back to back
	function automatic int draw_gap(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 13);
			default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
		endcase
	endfunction

	function automatic int rand_k();
		return int'($urandom_range(0, 1 << 20)) - (1 << 19);
	endfunction

	// mostly even steps keep slanted edges on the grid
	function automatic int rand_step();
		int d;
		d = 2 * $urandom_range(1, 8);
		if ($urandom_range(0, 15) == 0)
			d = d - 1;
		return d;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] to_db(input int k);
		return COORD_WIDTH'(k * (1 << FRAC_BITS));
	endfunction

	function automatic logic signed [LAYER_IN_W-1:0] pick_layer();
		if ($urandom_range(0, 11) == 0)
			return LAYER_IN_W'($urandom);
		return LAYER_IN_W'($urandom_range(0, cur_layers - 1));
	endfunction

	task automatic send_item(input logic cmd, input logic [KIND_W-1:0] kind,
			input logic signed [LAYER_IN_W-1:0] lyr, input logic [COUNT_W-1:0] cnt,
			input logic signed [COORD_WIDTH-1:0] x, input logic signed [COORD_WIDTH-1:0] y);
		int gap;
		gap = draw_gap(push_mode);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		element_kind <= kind;
		layer_index <= lyr;
		point_count <= cnt;
		coord_x <= x;
		coord_y <= y;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	// unused fields carry random bits
	task automatic send_header(input logic [KIND_W-1:0] kind,
			input logic signed [LAYER_IN_W-1:0] lyr, input int cnt);
		send_item(CMD_HEADER, kind, lyr, COUNT_W'(cnt), $urandom, $urandom);
	endtask

	task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
			input logic signed [COORD_WIDTH-1:0] y);
		send_item(CMD_POINT, KIND_W'($urandom), LAYER_IN_W'($urandom), COUNT_W'($urandom),
			x, y);
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (corners_due_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic apply_config(input int layers, input int scale, input int max_pts);
		settle();
		write_reg(REG_LAYER_COUNT, layers);
		write_reg(REG_GRID_SCALE, scale);
		write_reg(REG_POINT_LIMIT, max_pts);
		cfg_valid <= 1'b0;
		cur_layers = layers;
		settings_used++;
	endtask

	// manhattan/45 walk, closed by one vertical and one horizontal edge
	task automatic send_polygon(input int n, input logic signed [LAYER_IN_W-1:0] lyr);
		int x0, y0, x, y, d, i;
		send_header(KIND_POLY, lyr, n);
		x0 = 2 * rand_k();
		y0 = 2 * rand_k();
		x = x0;
		y = y0;
		send_point(to_db(x), to_db(y));
		for (i = 1; i < n - 1; i++) begin
			d = rand_step();
			case ($urandom_range(0, 5))
				0: x += d;
				1: x -= d;
				2: y += d;
				3: y -= d;
				4: begin
					x += d;
					y += d;
				end
				default: begin
					x += d;
					y -= d;
				end
			endcase
			send_point(to_db(x), to_db(y));
		end
		if (n > 1)
			send_point(to_db(x0), to_db(y));
	endtask

	task automatic send_rect(input logic signed [LAYER_IN_W-1:0] lyr);
		int x0, y0, w, h;
		x0 = 2 * rand_k();
		y0 = 2 * rand_k();
		w = 2 * (int'($urandom_range(0, 100)) - 50);
		h = 2 * (int'($urandom_range(0, 100)) - 50);
		send_header(KIND_RECT, lyr, 4);
		send_point(to_db(x0), to_db(y0));
		send_point(to_db(x0 + w), to_db(y0));
		send_point(to_db(x0 + w), to_db(y0 + h));
		send_point(to_db(x0), to_db(y0 + h));
	endtask

	task automatic send_sbox(input logic signed [LAYER_IN_W-1:0] lyr);
		int x0, y0, a, b;
		x0 = 2 * rand_k();
		y0 = 2 * rand_k();
		a = 2 * (int'($urandom_range(0, 40)) - 20);
		b = 2 * (int'($urandom_range(0, 40)) - 20);
		send_header(KIND_SBOX, lyr, 2);
		send_point(to_db(x0), to_db(y0));
		send_point(to_db(x0 + a), to_db(y0 + b));
	endtask

	// random header and raw coordinates; long counts are cut short
	task automatic send_noise();
		int cnt, n, i;
		logic signed [COORD_WIDTH-1:0] x, y;
		cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 6);
		n = (cnt > 8 || $urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : cnt;
		send_header(KIND_W'($urandom), LAYER_IN_W'($urandom), cnt);
		for (i = 0; i < n; i++) begin
			x = ($urandom_range(0, 3) == 0) ? COORD_WIDTH'(int'($urandom_range(0, 64)) - 32)
				: COORD_WIDTH'($urandom);
			y = ($urandom_range(0, 3) == 0) ? COORD_WIDTH'(int'($urandom_range(0, 64)) - 32)
				: COORD_WIDTH'($urandom);
			send_point(x, y);
		end
	endtask

	// result side: random gaps per item, plus one long hold-off on request
	initial begin
		int gap;
		int served;
		served = 0;
		wait (arst_n);
		forever begin
			if (hold_off_pop) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_pop = 1'b0;
			end
			gap = draw_gap(pop_mode);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			served++;
			if (served % 30 == 0)
				pop_mode = $urandom_range(0, 2);
		end
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int phase, sel, target, base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header errors, empty elements, rounding, clean shapes
		push_mode = 2;
		send_header(KIND_POLY, 9'sd0, 0);
		send_header(KIND_UNKNOWN, 9'sd255, 0);
		send_header(KIND_POLY, -9'sd128, 0);
		send_header(KIND_RECT, 9'sd15, 0);
		send_header(KIND_SBOX, 9'sd3, 0);
		send_point(32'sd16, 32'sd16);
		// halves round away from zero, coordinate extremes
		send_header(KIND_POLY, 9'sd1, 3);
		send_point(32'sd2, -32'sd2);
		send_point(-32'sd6, 32'sd6);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_header(KIND_RECT, 9'sd2, 4);
		send_point(32'sd0, 32'sd0);
		send_point(32'sd64, 32'sd0);
		send_point(32'sd64, 32'sd64);
		send_point(32'sd0, 32'sd64);
		send_header(KIND_SBOX, 9'sd3, 2);
		send_point(32'sd0, 32'sd0);
		send_point(32'sd64, 32'sd0);
		// oversized count, dropped by the next header
		send_header(KIND_POLY, 9'sd4, 1023);
		send_point(32'sd0, 32'sd0);
		send_header(KIND_POLY, 9'sd5, 2);
		send_point(32'sd16, 32'sd16);
		send_point(32'sd16, 32'sd16);
		send_header(KIND_POLY, 9'sd6, 3);
		send_point(32'sd0, 32'sd0);
		send_point(32'sd64, 32'sd32);
		send_point(32'sd0, 32'sd32);
		settings_used = 1;

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					apply_config(256, 64, 1023);
					target = 45;
				end
				1: begin
					apply_config(1, 1, 2);
					target = 25;
				end
				2: begin
					apply_config($urandom_range(1, 256), $urandom_range(1, 64),
						$urandom_range(2, 1023));
					target = 38;
				end
				3: begin
					apply_config(200, 0, 40);
					target = 12;
				end
				default: begin
					apply_config($urandom_range(1, 256), $urandom_range(1, 64),
						$urandom_range(2, 1023));
					target = 40;
				end
			endcase
			base = items_sent - strays_sent;
			while (items_sent - strays_sent - base < target) begin
				sel = $urandom_range(0, 99);
				if (sel % 8 == 0)
					push_mode = $urandom_range(0, 2);
				if (phase == 0 && items_sent - strays_sent - base >= 20 && settings_used == 2) begin
					// receiver holds off while a long polygon streams in
					hold_off_pop = 1'b1;
					push_mode = 0;
					send_polygon(30, pick_layer());
					settings_used++;
				end else if (phase == 2 && items_sent - strays_sent - base >= 25 &&
						settings_used == 5) begin
					settle();
					settings_used++;
				end else if (sel < 40) begin
					send_polygon(($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
						: $urandom_range(3, 10), pick_layer());
				end else if (sel < 55) begin
					send_rect(pick_layer());
				end else if (sel < 70) begin
					send_sbox(pick_layer());
				end else if (sel < 88) begin
					send_noise();
				end else begin
					send_rect(pick_layer());
					repeat ($urandom_range(1, 2)) begin
						send_point(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom));
						strays_sent++;
					end
				end
			end
		end

		settle();
		$display("covered %0d items (%0d stray points) under %0d register settings",
			items_sent, strays_sent, 6);
		$display("compared %0d corners, %0d register writes", corners_checked, reg_writes);
		if (mismatches == 0 && corners_due_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mpc_pkg.sv
src/mpc_front.sv
src/mpc_queue.sv
src/mpc_back.sv
src/manhattan45_polygon_checker.sv
tb/corner_checker.sv
tb/tb_top.sv
